// File: hw/rtl/csr_adjacency_intersect_engine_assert.svh
// assertion macros shared by the adjacency intersect engine
// no dependencies
`ifndef CSR_ADJACENCY_INTERSECT_ENGINE_ASSERT_SVH
`define CSR_ADJACENCY_INTERSECT_ENGINE_ASSERT_SVH
// a condition implies another in the next cycle
`define CAIE_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
// a condition implies another in the same cycle
`define CAIE_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
`endif

// File: hw/rtl/caie_pkg.sv
// constants and types for the adjacency intersect engine
// no dependencies
package caie_pkg;
   localparam int VERTICES = 1024;
   localparam int EDGES = 4096;
   localparam int COLORS = 4;
   localparam int VW = $clog2(VERTICES);
   localparam int EW = $clog2(EDGES);
   localparam int CW = $clog2(COLORS);
   localparam int OFS_AW = CW + VW;
   localparam int ADJ_AW = CW + EW;
   localparam logic [2:0] MODE_LOAD_OFS = 3'd0;
   localparam logic [2:0] MODE_LOAD_ADJ = 3'd1;
   localparam logic [2:0] MODE_INTERSECT = 3'd2;
   localparam logic [2:0] MODE_REMOVE_PAIR = 3'd3;
   localparam logic [2:0] MODE_REMOVE_IDX = 3'd4;
endpackage

// File: hw/rtl/caie_ram.sv
// generic single-port write, single-port read ram with registered read
// no dependencies
module caie_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hw/rtl/csr_adjacency_intersect_engine.sv
// adjacency intersect engine: per-color csr graph with merge-walk intersect
// depends on caie_pkg, caie_ram and the assertion macro header
//
// usage:
//  req_ channel takes one word per item, rsp_ returns exactly one word per item.
//  csr_ channel writes edge_count; write only while the block is idle.
//  loads show their result in the cycle after acceptance.
//  intersect reads two offset pairs, then walks both ranges through the
//  single adjacency read port: a merge step reads i then j, and a removed
//  entry is skipped.
//  remove pair reads the same offsets, then scans the first range and then
//  the second entry by entry, moving on when a direction runs out of its range.
//  remove index does a read-modify-write, and skips it when out of bounds.
//  one item is in work at a time; req_tready is low while busy.
//  the result sits in an output register; a stalled receiver holds the
//  block in its done state until rsp_tready.
//  reset clears control state and edge_count; the stores are undefined
//  until loaded, no clearing pass is run.
`include "csr_adjacency_intersect_engine_assert.svh"
module csr_adjacency_intersect_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[2:0] first_vertex[12:3] second_vertex[22:13] edge_index[34:23]
   // load_value[47:35]
   input  logic [47:0] req_tdata,
   // color[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // common_count[12:0] success[13], zero filled
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_data
);
   localparam int VW = caie_pkg::VW;
   localparam int EW = caie_pkg::EW;
   localparam int OAW = caie_pkg::OFS_AW;
   localparam int AAW = caie_pkg::ADJ_AW;

   typedef enum logic [3:0] {
      S_IDLE, S_OFS0, S_OFS1, S_OFS2, S_OFS3,
      S_RD, S_EVAL, S_IDXRD, S_IDXEVAL, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] mode_ff, mode_in;
   logic [1:0] color_ff, color_in;
   logic [VW-1:0] fv_ff, fv_in, sv_ff, sv_in;
   logic [EW-1:0] ei_ff, ei_in;
   logic [12:0] lv_ff, lv_in;
   logic [12:0] ec_ff, ec_in;
   // range pointers, one bit wider to hold EDGES
   logic [EW:0] i_ff, i_in, ie_ff, ie_in, j_ff, j_in, je_ff, je_in;
   logic [VW-1:0] ai_ff, ai_in;  // neighbour read from the i side
   logic side_ff, side_in;       // 0 reads i, 1 reads j
   logic pass_ff, pass_in;       // remove pair direction
   logic found_ff, found_in;
   logic [12:0] cnt_ff, cnt_in;
   logic ok_ff, ok_in;

   logic ofs_we, adj_we;
   logic [OAW-1:0] ofs_wa, ofs_ra;
   logic [12:0] ofs_wd, ofs_rd;
   logic [AAW-1:0] adj_wa, adj_ra;
   logic [VW:0] adj_wd, adj_rd;

   caie_ram #(.WIDTH(13), .DEPTH(caie_pkg::COLORS * caie_pkg::VERTICES)) u_ofs (
      .clock(clock), .wr_en(ofs_we), .wr_addr(ofs_wa), .wr_data(ofs_wd),
      .rd_addr(ofs_ra), .rd_data(ofs_rd));
   caie_ram #(.WIDTH(VW + 1), .DEPTH(caie_pkg::COLORS * caie_pkg::EDGES)) u_adj (
      .clock(clock), .wr_en(adj_we), .wr_addr(adj_wa), .wr_data(adj_wd),
      .rd_addr(adj_ra), .rd_data(adj_rd));

   function automatic logic [EW:0] clamp(input logic [12:0] x);
      logic [EW:0] r;
      if ({19'd0, x} > 32'(caie_pkg::EDGES)) r = (EW + 1)'(caie_pkg::EDGES);
      else r = (EW + 1)'(x);
      return r;
   endfunction

   logic [EW:0] cur_k, cur_end;
   logic [VW-1:0] cur_tgt;
   logic in_range;
   logic [EW:0] rd_ptr;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = (state_ff == S_DONE);
   assign rsp_tdata = {2'b00, ok_ff, cnt_ff};

   always_comb begin
      cur_k = pass_ff ? j_ff : i_ff;
      cur_end = pass_ff ? je_ff : ie_ff;
      cur_tgt = pass_ff ? fv_ff : sv_ff;
      in_range = (cur_k < cur_end);
      rd_ptr = side_ff ? j_ff : i_ff;
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff; color_in = color_ff; fv_in = fv_ff; sv_in = sv_ff;
      ei_in = ei_ff; lv_in = lv_ff;
      ec_in = csr_valid ? csr_data : ec_ff;
      i_in = i_ff; ie_in = ie_ff; j_in = j_ff; je_in = je_ff;
      ai_in = ai_ff; side_in = side_ff; pass_in = pass_ff;
      found_in = found_ff; cnt_in = cnt_ff; ok_in = ok_ff;
      ofs_we = 1'b0; ofs_wa = {color_ff, fv_ff}; ofs_wd = lv_ff;
      ofs_ra = {color_ff, fv_ff};
      adj_we = 1'b0; adj_wa = {color_ff, ei_ff}; adj_wd = adj_rd;
      adj_ra = {color_ff, rd_ptr[EW-1:0]};
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tdata[2:0];
               fv_in = req_tdata[12:3];
               sv_in = req_tdata[22:13];
               ei_in = req_tdata[34:23];
               lv_in = req_tdata[47:35];
               color_in = req_tuser;
               cnt_in = '0; ok_in = 1'b0; pass_in = 1'b0; side_in = 1'b0;
               found_in = 1'b0;
               unique case (req_tdata[2:0])
                  caie_pkg::MODE_LOAD_OFS: begin
                     ofs_we = 1'b1; ofs_wa = {req_tuser, req_tdata[12:3]};
                     ofs_wd = req_tdata[47:35]; ok_in = 1'b1; state_in = S_DONE;
                  end
                  caie_pkg::MODE_LOAD_ADJ: begin
                     adj_we = 1'b1; adj_wa = {req_tuser, req_tdata[34:23]};
                     adj_wd = {1'b0, req_tdata[35 +: VW]};
                     ok_in = 1'b1; state_in = S_DONE;
                  end
                  caie_pkg::MODE_INTERSECT, caie_pkg::MODE_REMOVE_PAIR: begin
                     ok_in = (req_tdata[2:0] == caie_pkg::MODE_INTERSECT);
                     ofs_ra = {req_tuser, req_tdata[12:3] - VW'(1)};
                     state_in = S_OFS0;
                  end
                  caie_pkg::MODE_REMOVE_IDX: begin
                     if (req_tdata[34:23] < ec_ff[EW-1:0] || ec_ff[12]) begin
                        adj_ra = {req_tuser, req_tdata[34:23]};
                        state_in = S_IDXRD;
                     end else state_in = S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         // offset reads land in the cycle after their address
         S_OFS0: begin
            i_in = (fv_ff == '0) ? '0 : clamp(ofs_rd);
            ofs_ra = {color_ff, fv_ff};
            state_in = S_OFS1;
         end
         S_OFS1: begin
            ie_in = clamp(ofs_rd);
            if (i_ff > clamp(ofs_rd)) i_in = clamp(ofs_rd);
            ofs_ra = {color_ff, sv_ff - VW'(1)};
            state_in = S_OFS2;
         end
         S_OFS2: begin
            j_in = (sv_ff == '0) ? '0 : clamp(ofs_rd);
            ofs_ra = {color_ff, sv_ff};
            state_in = S_OFS3;
         end
         S_OFS3: begin
            je_in = clamp(ofs_rd);
            if (j_ff > clamp(ofs_rd)) j_in = clamp(ofs_rd);
            state_in = S_RD;
         end
         S_RD: begin
            // issue read at the current pointer
            if (mode_ff == caie_pkg::MODE_INTERSECT) begin
               if (!(i_ff < ie_ff && j_ff < je_ff)) state_in = S_DONE;
               else state_in = S_EVAL;
            end else begin
               adj_ra = {color_ff, cur_k[EW-1:0]};
               if (!in_range) begin
                  if (pass_ff) begin
                     ok_in = found_ff & 1'b0;
                     state_in = S_DONE;
                  end else begin
                     pass_in = 1'b1; state_in = S_RD;
                  end
               end else state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (mode_ff == caie_pkg::MODE_INTERSECT) begin
               if (!side_ff) begin
                  if (adj_rd[VW]) begin
                     i_in = i_ff + 1'b1;
                     state_in = S_RD;
                  end else begin
                     ai_in = adj_rd[VW-1:0]; side_in = 1'b1; state_in = S_RD;
                  end
               end else begin
                  side_in = 1'b0;
                  state_in = S_RD;
                  if (adj_rd[VW]) j_in = j_ff + 1'b1;
                  else if (ai_ff == adj_rd[VW-1:0]) begin
                     cnt_in = cnt_ff + 1'b1; i_in = i_ff + 1'b1; j_in = j_ff + 1'b1;
                  end else if (ai_ff > adj_rd[VW-1:0]) j_in = j_ff + 1'b1;
                  else i_in = i_ff + 1'b1;
               end
            end else begin
               if (!adj_rd[VW] && adj_rd[VW-1:0] == cur_tgt) begin
                  adj_we = 1'b1; adj_wa = {color_ff, cur_k[EW-1:0]};
                  adj_wd = {1'b1, adj_rd[VW-1:0]};
                  if (pass_ff) begin
                     ok_in = found_ff; state_in = S_DONE;
                  end else begin
                     found_in = 1'b1; pass_in = 1'b1; state_in = S_RD;
                  end
               end else begin
                  if (pass_ff) j_in = j_ff + 1'b1;
                  else i_in = i_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_IDXRD: begin
            adj_ra = {color_ff, ei_ff};
            state_in = S_IDXEVAL;
         end
         S_IDXEVAL: begin
            adj_we = 1'b1; adj_wd = {1'b1, adj_rd[VW-1:0]};
            ok_in = 1'b1; state_in = S_DONE;
         end
         S_DONE: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ec_ff <= '0;
      end else begin
         state_ff <= state_in;
         ec_ff <= ec_in;
      end
      mode_ff <= mode_in; color_ff <= color_in; fv_ff <= fv_in; sv_ff <= sv_in;
      ei_ff <= ei_in; lv_ff <= lv_in;
      i_ff <= i_in; ie_ff <= ie_in; j_ff <= j_in; je_ff <= je_in;
      ai_ff <= ai_in; side_ff <= side_in; pass_ff <= pass_in;
      found_ff <= found_in; cnt_ff <= cnt_in; ok_ff <= ok_in;
   end

   logic rsp_stall, ofs_load_acc;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign ofs_load_acc = req_tvalid && req_tready &&
                         (req_tdata[2:0] == caie_pkg::MODE_LOAD_OFS);

   `CAIE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   `CAIE_ASSERT_NOW(a_no_accept_busy, clock, reset, rsp_tvalid, !req_tready)
   `CAIE_ASSERT_NEXT(a_load_done, clock, reset, ofs_load_acc, rsp_tvalid)
endmodule

// File: tb/csr_adjacency_intersect_checker.sv
// checker for the adjacency intersect engine: predicts every rsp word from req and csr traffic
// and compares it field by field; depends on caie_pkg
module csr_adjacency_intersect_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [12:0] csr_data,
   output int          fail_count,
   output int          awaiting
);
   typedef struct packed {
      logic [12:0] common_count;
      logic        success;
   } rsp_word_type;

   logic [12:0]  end_ofs [caie_pkg::COLORS][caie_pkg::VERTICES];
   logic [9:0]   nbr     [caie_pkg::COLORS][caie_pkg::EDGES];
   bit           gone    [caie_pkg::COLORS][caie_pkg::EDGES];
   logic [12:0]  edge_limit;
   rsp_word_type result_q [$];

   initial begin
      for (int c = 0; c < caie_pkg::COLORS; c++) begin
         for (int v = 0; v < caie_pkg::VERTICES; v++) end_ofs[c][v] = '0;
         for (int e = 0; e < caie_pkg::EDGES; e++) begin
            nbr[c][e] = '0;
            gone[c][e] = 1'b0;
         end
      end
   end

   function automatic int clamp_edge(int x);
      return (x > caie_pkg::EDGES) ? caie_pkg::EDGES : x;
   endfunction

   function automatic void span(int c, int v, output int lo, output int hi);
      lo = (v == 0) ? 0 : clamp_edge(int'(end_ofs[c][v-1]));
      hi = clamp_edge(int'(end_ofs[c][v]));
      if (lo > hi) lo = hi;
   endfunction

   // merge walk over two sorted ranges, removed entries skipped
   function automatic int common_nbrs(int c, int u, int v);
      int i, ie, j, je, n;
      n = 0;
      span(c, u, i, ie);
      span(c, v, j, je);
      while (i < ie && j < je) begin
         if (gone[c][i]) i++;
         else if (gone[c][j]) j++;
         else if (nbr[c][i] == nbr[c][j]) begin
            n++;
            i++;
            j++;
         end else if (nbr[c][i] > nbr[c][j]) j++;
         else i++;
      end
      return n;
   endfunction

   function automatic bit strike(int c, int v, logic [9:0] target);
      int lo, hi;
      span(c, v, lo, hi);
      for (int k = lo; k < hi; k++) begin
         if (!gone[c][k] && nbr[c][k] == target) begin
            gone[c][k] = 1'b1;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_word_type predict(logic [2:0] mode, logic [1:0] c, logic [9:0] fv,
                                            logic [9:0] sv, logic [11:0] ei, logic [12:0] lv);
      rsp_word_type r;
      bit a, b;
      int n;
      r = '0;
      case (mode)
         caie_pkg::MODE_LOAD_OFS: begin
            end_ofs[c][fv] = lv;
            r.success = 1'b1;
         end
         caie_pkg::MODE_LOAD_ADJ: begin
            nbr[c][ei] = lv[9:0];
            gone[c][ei] = 1'b0;
            r.success = 1'b1;
         end
         caie_pkg::MODE_INTERSECT: begin
            n = common_nbrs(c, fv, sv);
            r.common_count = n[12:0];
            r.success = 1'b1;
         end
         caie_pkg::MODE_REMOVE_PAIR: begin
            a = strike(c, fv, sv);
            b = strike(c, sv, fv);
            r.success = a && b;
         end
         caie_pkg::MODE_REMOVE_IDX: begin
            if (13'(ei) < edge_limit) begin
               gone[c][ei] = 1'b1;
               r.success = 1'b1;
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         edge_limit = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               $display("%0t rsp word with nothing expected: actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp_tdata[12:0] !== want.common_count) begin
                  $display("%0t common_count mismatch: expected %0d actual %0d",
                           $time, want.common_count, rsp_tdata[12:0]);
                  fail_count++;
               end
               if (rsp_tdata[13] !== want.success) begin
                  $display("%0t success mismatch: expected %0d actual %0d",
                           $time, want.success, rsp_tdata[13]);
                  fail_count++;
               end
               if (rsp_tdata[15:14] !== 2'b00) begin
                  $display("%0t fill bits mismatch: expected 0 actual %b",
                           $time, rsp_tdata[15:14]);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) edge_limit = csr_data;
         if (req_tvalid && req_tready)
            result_q = {result_q, predict(req_tdata[2:0], req_tuser, req_tdata[12:3],
                                          req_tdata[22:13], req_tdata[34:23],
                                          req_tdata[47:35])};
      end
      awaiting = result_q.size();
   end
endmodule

// File: tb/tb_csr_adjacency_intersect_engine.sv
// top of the adjacency intersect engine testbench: stimulus, clock, reset and verdict
// depends on caie_pkg, the engine rtl and csr_adjacency_intersect_checker
module tb_csr_adjacency_intersect_engine;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_data = '0;
   int          fail_count;
   int          awaiting;

   typedef struct {
      logic [1:0] c;
      logic [9:0] v;
   } vtx_type;

   // shadow of what has been written, so no never-written entry is ever read
   logic [12:0] ofs_sh [caie_pkg::COLORS][caie_pkg::VERTICES];
   bit          ofs_wr [caie_pkg::COLORS][caie_pkg::VERTICES];
   logic [9:0]  nb_sh  [caie_pkg::COLORS][caie_pkg::EDGES];
   bit          adj_wr [caie_pkg::COLORS][caie_pkg::EDGES];
   vtx_type     built [$];
   bit          no_idle = 1'b0;
   logic [12:0] ec_sh = '0;
   int          items_sent = 0;
   int          mode_seen [8];
   int          csr_writes = 0;
   int          quiet = 0;

   always #4 clock = ~clock;

   csr_adjacency_intersect_engine uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   csr_adjacency_intersect_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .awaiting(awaiting)
   );

   always @(posedge clock) begin
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= 24);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= 20000) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic void vrange(int c, int v, output int lo, output int hi);
      lo = (v == 0) ? 0 : int'(ofs_sh[c][v-1]);
      hi = int'(ofs_sh[c][v]);
      if (lo > caie_pkg::EDGES) lo = caie_pkg::EDGES;
      if (hi > caie_pkg::EDGES) hi = caie_pkg::EDGES;
      if (lo > hi) lo = hi;
   endfunction

   // a vertex may be walked only when its offsets and every entry in its range were loaded
   function automatic bit range_ok(int c, int v);
      int lo, hi;
      if (!ofs_wr[c][v] || (v > 0 && !ofs_wr[c][v-1])) return 1'b0;
      vrange(c, v, lo, hi);
      if (hi - lo > 48) return 1'b0;
      for (int k = lo; k < hi; k++) if (!adj_wr[c][k]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic send(input logic [2:0] m, input logic [1:0] c, input logic [9:0] fv,
                       input logic [9:0] sv, input logic [11:0] ei, input logic [12:0] lv);
      int gap;
      gap = 0;
      if (!no_idle) while ($urandom_range(0, 99) < 24) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {lv, ei, sv, fv, m};
      req_tuser <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (m == caie_pkg::MODE_LOAD_OFS) begin
         ofs_sh[c][fv] = lv;
         ofs_wr[c][fv] = 1'b1;
      end else if (m == caie_pkg::MODE_LOAD_ADJ) begin
         nb_sh[c][ei] = lv[9:0];
         adj_wr[c][ei] = 1'b1;
      end
      items_sent++;
      mode_seen[m]++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic [12:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      ec_sh = v;
      csr_writes++;
   endtask

   // well-formed csr segment: offsets for b-1..b+k-1 and sorted neighbour lists
   task automatic build(input logic [1:0] c, input int b, input int k);
      int pos, d, nb;
      vtx_type t;
      pos = ($urandom_range(0, 3) == 0) ? caie_pkg::EDGES - 48
                                        : $urandom_range(0, caie_pkg::EDGES - 48);
      // vertex 0 always starts at slot 0
      if (b == 0) pos = 0;
      if (b > 0)
         send(caie_pkg::MODE_LOAD_OFS, c, 10'(b - 1), 10'($urandom), 12'($urandom), 13'(pos));
      for (int i = 0; i < k; i++) begin
         d = $urandom_range(0, 6);
         nb = ($urandom_range(0, 7) == 0) ? 1000 + $urandom_range(0, 4) : $urandom_range(0, 4);
         for (int j = 0; j < d; j++) begin
            send(caie_pkg::MODE_LOAD_ADJ, c, 10'($urandom), 10'($urandom), 12'(pos),
                 13'(nb + 1024 * $urandom_range(0, 7)));
            pos++;
            nb += $urandom_range(1, 3);
         end
         send(caie_pkg::MODE_LOAD_OFS, c, 10'(b + i), 10'($urandom), 12'($urandom), 13'(pos));
         t.c = c;
         t.v = 10'(b + i);
         built = {built, t};
         if (built.size() > 64) void'(built.pop_front());
      end
   endtask

   function automatic vtx_type pick();
      return built[$urandom_range(0, built.size() - 1)];
   endfunction

   task automatic random_phase(input int n);
      int start, r, k, lo, hi, b;
      vtx_type a, o;
      logic [9:0] sv;
      logic [11:0] ei;
      start = items_sent;
      while (items_sent - start < n) begin
         r = $urandom_range(0, 99);
         a = pick();
         if (r < 12) begin
            k = $urandom_range(1, 6);
            case ($urandom_range(0, 3))
               0: b = 0;
               1: b = caie_pkg::VERTICES - k;
               default: b = $urandom_range(1, caie_pkg::VERTICES - k);
            endcase
            build(2'($urandom), b, k);
         end else if (r < 67 && !range_ok(a.c, a.v)) begin
            send(caie_pkg::MODE_LOAD_ADJ, 2'($urandom), 10'($urandom), 10'($urandom),
                 12'($urandom), 13'($urandom));
         end else if (r < 47) begin
            o = pick();
            sv = ($urandom_range(0, 3) != 0 && range_ok(a.c, o.v)) ? o.v : a.v;
            send(caie_pkg::MODE_INTERSECT, a.c, a.v, sv, 12'($urandom), 13'($urandom));
         end else if (r < 67) begin
            vrange(a.c, a.v, lo, hi);
            if (hi > lo && $urandom_range(0, 3) != 0) begin
               sv = nb_sh[a.c][$urandom_range(lo, hi - 1)];
            end else begin
               o = pick();
               sv = o.v;
            end
            if (!range_ok(a.c, sv)) sv = a.v;
            send(caie_pkg::MODE_REMOVE_PAIR, a.c, a.v, sv, 12'($urandom), 13'($urandom));
         end else if (r < 77) begin
            vrange(a.c, a.v, lo, hi);
            if (hi > lo && $urandom_range(0, 1) == 0) ei = 12'($urandom_range(lo, hi - 1));
            else ei = 12'($urandom);
            if (13'(ei) < ec_sh && !adj_wr[a.c][ei])
               send(caie_pkg::MODE_LOAD_ADJ, a.c, 10'($urandom), 10'($urandom), ei,
                    13'($urandom));
            else
               send(caie_pkg::MODE_REMOVE_IDX, a.c, 10'($urandom), 10'($urandom), ei,
                    13'($urandom));
         end else if (r < 87) begin
            send(caie_pkg::MODE_LOAD_ADJ, 2'($urandom), 10'($urandom), 10'($urandom),
                 12'($urandom), 13'($urandom));
         end else if (r < 93) begin
            send(caie_pkg::MODE_LOAD_OFS, 2'($urandom), 10'($urandom), 10'($urandom),
                 12'($urandom), 13'($urandom));
         end else begin
            send(3'($urandom_range(5, 7)), 2'($urandom), 10'($urandom), 10'($urandom),
                 12'($urandom), 13'($urandom));
         end
      end
   endtask

   initial begin
      vtx_type t;
      for (int c = 0; c < caie_pkg::COLORS; c++) begin
         for (int v = 0; v < caie_pkg::VERTICES; v++) begin
            ofs_sh[c][v] = '0;
            ofs_wr[c][v] = 1'b0;
         end
         for (int e = 0; e < caie_pkg::EDGES; e++) begin
            nb_sh[c][e] = '0;
            adj_wr[c][e] = 1'b0;
         end
      end
      for (int m = 0; m < 8; m++) mode_seen[m] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      csr_write(13'd0);

      // directed: segment edges, top slots, wrap of neighbour ids, empty and clamped ranges
      build(2'd0, 0, 4);
      build(2'd0, caie_pkg::VERTICES - 4, 4);
      build(2'd3, 500, 3);
      send(caie_pkg::MODE_LOAD_ADJ, 2'd1, 10'd0, 10'd0, 12'd4095, 13'd8191);
      send(caie_pkg::MODE_LOAD_ADJ, 2'd1, 10'd1023, 10'd1023, 12'd4094, 13'd1024);
      send(caie_pkg::MODE_LOAD_OFS, 2'd1, 10'd1022, 10'd0, 12'd0, 13'd4094);
      send(caie_pkg::MODE_LOAD_OFS, 2'd1, 10'd1023, 10'd0, 12'd4095, 13'd4096);
      t.c = 2'd1;
      t.v = 10'd1023;
      built = {built, t};
      send(caie_pkg::MODE_INTERSECT, 2'd1, 10'd1023, 10'd1023, 12'd0, 13'd0);
      // source equals destination: second search sees the first mark
      send(caie_pkg::MODE_REMOVE_PAIR, 2'd1, 10'd1023, 10'd1023, 12'd4095, 13'd8191);
      send(caie_pkg::MODE_REMOVE_IDX, 2'd1, 10'd0, 10'd0, 12'd4095, 13'd0);
      send(caie_pkg::MODE_LOAD_OFS, 2'd2, 10'd0, 10'd0, 12'd0, 13'd8191);
      send(caie_pkg::MODE_LOAD_OFS, 2'd2, 10'd10, 10'd0, 12'd0, 13'd4000);
      send(caie_pkg::MODE_LOAD_OFS, 2'd2, 10'd11, 10'd0, 12'd0, 13'd5);
      send(caie_pkg::MODE_INTERSECT, 2'd2, 10'd11, 10'd11, 12'd4095, 13'd8191);
      send(caie_pkg::MODE_INTERSECT, 2'd0, 10'd0, 10'd1, 12'd0, 13'd0);
      send(caie_pkg::MODE_INTERSECT, 2'd0, 10'd1020, 10'd1023, 12'd0, 13'd0);
      send(caie_pkg::MODE_REMOVE_PAIR, 2'd0, 10'd1023, 10'd0, 12'd0, 13'd0);
      for (int m = 5; m < 8; m++) send(3'(m), 2'd3, 10'd1023, 10'd1023, 12'd4095, 13'd8191);

      csr_write(13'd4096);
      send(caie_pkg::MODE_REMOVE_IDX, 2'd1, 10'd0, 10'd0, 12'd4095, 13'd0);
      send(caie_pkg::MODE_INTERSECT, 2'd1, 10'd1023, 10'd1023, 12'd0, 13'd0);
      send(caie_pkg::MODE_LOAD_ADJ, 2'd1, 10'd0, 10'd0, 12'd4095, 13'd1023);
      send(caie_pkg::MODE_INTERSECT, 2'd1, 10'd1023, 10'd1023, 12'd0, 13'd0);
      random_phase(450);

      csr_write(13'd8191);
      no_idle = 1'b1;
      random_phase(300);
      no_idle = 1'b0;

      csr_write(13'($urandom_range(0, 4096)));
      random_phase(500);

      csr_write(13'd1);
      random_phase(450);

      wait_idle();
      $display("covered %0d items: %0d offset loads, %0d adjacency loads, %0d intersects,",
               items_sent, mode_seen[0], mode_seen[1], mode_seen[2]);
      $display("%0d pair removals, %0d index removals, %0d unused modes, %0d edge_count writes",
               mode_seen[3], mode_seen[4], mode_seen[5] + mode_seen[6] + mode_seen[7],
               csr_writes);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
